### src/b64d_pkg.sv
// shared types, constants and helpers for the base64 stream decoder
`default_nettype none

package b64d_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned SextetW = 6;
  localparam int unsigned WordW   = 24;
  localparam int unsigned HeldW   = 18;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7A;
  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit9 = 8'h39;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChSlash  = 8'h2F;

  localparam logic [5:0] LowerBase = 6'd26;
  localparam logic [5:0] DigitBase = 6'd52;
  localparam logic [5:0] PlusCode  = 6'd62;
  localparam logic [5:0] SlashCode = 6'd63;

  typedef struct packed {
    logic         hit;
    logic [5:0]   sextet;
  } sextet_t;

  // one decoded group handed from front to back
  typedef struct packed {
    logic [WordW-1:0] word;
    logic [1:0]       nbytes;
    logic             eot;
  } job_t;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       eot;
    logic       last;
  } beat_t;

  function automatic sextet_t map_char(input logic [CharW-1:0] c);
    sextet_t    r;
    logic [7:0] t;
    r.hit    = 1'b1;
    r.sextet = '0;
    t        = '0;
    if (c >= ChUpperA && c <= ChUpperZ) begin
      t        = c - ChUpperA;
      r.sextet = t[5:0];
    end else if (c >= ChLowerA && c <= ChLowerZ) begin
      t        = c - ChLowerA;
      r.sextet = t[5:0] + LowerBase;
    end else if (c >= ChDigit0 && c <= ChDigit9) begin
      t        = c - ChDigit0;
      r.sextet = t[5:0] + DigitBase;
    end else if (c == ChPlus) begin
      r.sextet = PlusCode;
    end else if (c == ChSlash) begin
      r.sextet = SlashCode;
    end else begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

  function automatic beat_t make_beat(input job_t j, input logic [1:0] idx);
    beat_t b;
    b.eot = j.eot;
    if (j.nbytes == 2'd0) begin
      b.data       = '0;
      b.byte_valid = 1'b0;
      b.last       = 1'b1;
    end else begin
      b.byte_valid = 1'b1;
      b.last       = (idx == (j.nbytes - 2'd1));
      case (idx)
        2'd0:    b.data = j.word[23:16];
        2'd1:    b.data = j.word[15:8];
        default: b.data = j.word[7:0];
      endcase
    end
    return b;
  endfunction

endpackage

`default_nettype wire

### src/base64_stream_decoder.sv
// top level of the streaming base64 decoder
//
// input stream: one text character per beat on s_axis; characters of the
// standard alphabet are collected four at a time, any other byte ends the text
// output stream: one decoded byte per beat on m_axis; tuser carries
// byte_valid and end_of_text, tlast marks the final beat caused by one input
// a full group of four characters gives three beats, an end character gives
// one or two byte beats, or a single empty beat when no bytes are pending
// the first beat of a group passes through the job queue and the output
// register after the character that completes it is taken
// throughput: one character per cycle; s_axis_tready drops only when the
// two-entry job queue is full, which the three-beat burst of a group and the
// one-beat-per-cycle output register set
// reset clears the held characters, the queue and the output register
// when the receiver stalls the output beat holds, the queue fills and then
// the input is stalled in turn
`default_nettype none

module base64_stream_decoder
  import b64d_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // char_in
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // data_byte
  output logic [1:0]      m_axis_tuser,   // end_of_text, byte_valid
  output logic            m_axis_tlast    // last
);

  logic  q_full, push, pop, head_valid;
  job_t  job, head;
  beat_t beat;

  b64d_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .char_i   (s_axis_tdata),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (job)
  );

  b64d_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .job_i        (job),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  b64d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .beat_o       (beat)
  );

  assign m_axis_tdata = beat.data;
  assign m_axis_tuser = {beat.eot, beat.byte_valid};
  assign m_axis_tlast = beat.last;

endmodule

`default_nettype wire

### src/b64d_front.sv
// front end: character classification and sextet accumulation
`default_nettype none

module b64d_front
  import b64d_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire logic [CharW-1:0] char_i,
  input  wire logic             q_full_i,
  output logic                  push_o,
  output job_t                  job_o
);

  logic [HeldW-1:0] held_q, held_d;
  logic [1:0]       cnt_q, cnt_d;
  sextet_t          sx;
  logic             accept;

  assign ready_o = !q_full_i;
  assign accept  = valid_i && ready_o;
  assign sx      = map_char(char_i);

  always_comb begin
    held_d      = held_q;
    cnt_d       = cnt_q;
    push_o      = 1'b0;
    job_o.word  = '0;
    job_o.nbytes = 2'd0;
    job_o.eot   = 1'b0;
    if (sx.hit) begin
      job_o.word   = {held_q, sx.sextet};
      job_o.nbytes = 2'd3;
    end else begin
      job_o.eot = 1'b1;
      case (cnt_q)
        2'd2: begin
          job_o.word   = {held_q[11:0], 12'd0};
          job_o.nbytes = 2'd1;
        end
        2'd3: begin
          job_o.word   = {held_q, 6'd0};
          job_o.nbytes = 2'd2;
        end
        default: begin
          job_o.word   = '0;
          job_o.nbytes = 2'd0;
        end
      endcase
    end
    if (accept) begin
      if (sx.hit && cnt_q != 2'd3) begin
        held_d = {held_q[HeldW-SextetW-1:0], sx.sextet};
        cnt_d  = cnt_q + 2'd1;
      end else begin
        push_o = 1'b1;
        held_d = '0;
        cnt_d  = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      cnt_q  <= 2'd0;
    end else begin
      held_q <= held_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### src/b64d_fifo.sv
// short job queue between front and back
`default_nettype none

module b64d_fifo
  import b64d_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      head_valid_o,
  output job_t      head_o
);

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o       = (cnt_q == QCntW'(QDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + QPtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCntW'(1);
        2'b01:   cnt_q <= cnt_q - QCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/b64d_back.sv
// back end: splits each job into output beats behind an output register
`default_nettype none

module b64d_back
  import b64d_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic head_valid_i,
  input  wire job_t head_i,
  output logic      pop_o,
  output logic      valid_o,
  input  wire logic ready_i,
  output beat_t     beat_o
);

  job_t       job_q, job_d;
  logic [1:0] idx_q, idx_d;
  logic       busy_q, busy_d;
  logic       out_q, out_d;
  beat_t      beat_q, beat_d;
  logic       out_free;
  logic       emit;
  job_t       src;
  logic [1:0] src_idx;
  beat_t      nb;

  assign out_free = !out_q || ready_i;
  assign src      = busy_q ? job_q : head_i;
  assign src_idx  = busy_q ? idx_q : 2'd0;
  assign nb       = make_beat(src, src_idx);
  assign emit     = out_free && (busy_q || head_valid_i);
  assign pop_o    = out_free && !busy_q && head_valid_i;
  assign valid_o  = out_q;
  assign beat_o   = beat_q;

  always_comb begin
    job_d  = job_q;
    idx_d  = idx_q;
    busy_d = busy_q;
    out_d  = out_q;
    beat_d = beat_q;
    if (out_free) begin
      out_d = emit;
    end
    if (emit) begin
      beat_d = nb;
      job_d  = src;
      idx_d  = src_idx + 2'd1;
      busy_d = !nb.last;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    idx_q  <= idx_d;
    beat_q <= beat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      out_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      out_q  <= out_d;
    end
  end

endmodule

`default_nettype wire

### src/b64d_checker.sv
// port-level checks for the base64 stream decoder
`default_nettype none

module b64d_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic [1:0] m_axis_tuser,
  input wire logic       m_axis_tlast
);

  // stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // an empty beat is a lone end marker
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tuser[1] && m_axis_tlast && m_axis_tdata == 8'd0)
    else $error("empty beat malformed");

  // mid-text beats always carry a byte
  a_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("mid-text beat without byte");

  // a non-last beat is followed by more of its group, with the same end_of_text flag
  a_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && (m_axis_tuser[1] == $past(m_axis_tuser[1])))
    else $error("group broken");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
